>>> rtl/humidity_temp_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HTFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htfd assertion failed");

// Next-cycle implication, disabled during reset
`define HTFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htfd assertion failed");

`endif

>>> rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Types and constants of the humidity/temperature frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    // CRC-8, polynomial 0x31, MSB first
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;

    // Scaling constants
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    // Byte position within a six-byte reply
    typedef enum logic [2:0] {
        POS_T_HIGH = 3'd0,
        POS_T_LOW  = 3'd1,
        POS_T_CRC  = 3'd2,
        POS_H_HIGH = 3'd3,
        POS_H_LOW  = 3'd4,
        POS_H_CRC  = 3'd5
    } pos_t;

    // Raw words of one complete reply
    typedef struct packed {
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        logic        crc_fail;
    } frame_t;

endpackage

`default_nettype wire

>>> rtl/humidity_temp_frame_decoder.sv
// Once accepted, a sixth byte passes the frame, multiply and result registers.
// Throughput: one byte per cycle while byte_stall is low; the CRC step and the
// multiply and divide-by-65535 stages are registered; bytes stream back to back.
// A stalled result only holds the input once the pipeline slots behind it fill.
// Reset (rst_n, async, active low) clears position to the first byte, CRC to 0xFF.
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes a six-byte humidity/temperature reply with CRC-8 check into
// scaled temperature, humidity and a CRC status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_decoder_macros.svh"

module humidity_temp_frame_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_start,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [14:0]      temperature_centi,
    output logic [13:0]             humidity_centi,
    output logic                    frame_status
);
    import htfd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        take;
    logic        accept;
    logic        f_valid;
    logic        f_ready;
    frame_t      f_word;

    // Input register
    always_comb
    begin
        byte_stall = in_valid_reg && !take;
        accept     = byte_valid && !byte_stall;
        if (accept)
            in_valid_next = 1'b1;
        else if (take)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= rx_byte;
            in_start_reg <= frame_start;
        end
    end

    // Reply tracking and CRC
    htfd_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_ready  (in_valid_reg),
        .byte_data   (in_byte_reg),
        .byte_start  (in_start_reg),
        .take        (take),
        .frame_valid (f_valid),
        .frame       (f_word),
        .frame_ready (f_ready)
    );

    // Scaling to hundredths
    htfd_scaler u_scaler (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (f_valid),
        .frame       (f_word),
        .frame_ready (f_ready),
        .res_valid   (result_valid),
        .res_temp    (temperature_centi),
        .res_hum     (humidity_centi),
        .res_status  (frame_status),
        .res_stall   (result_stall)
    );

    // Checks
    `HTFD_ASSERT_NOW(a_take_needs_byte, take, in_valid_reg)
    `HTFD_ASSERT_NEXT(a_frame_holds, f_valid && !f_ready, f_valid && $stable(f_word))
    `HTFD_ASSERT_NOW(a_hum_range, result_valid, humidity_centi <= 14'd10000)
    `HTFD_ASSERT_NOW(a_temp_range, result_valid,
        (temperature_centi >= -15'sd4500) && (temperature_centi <= 15'sd13000))

endmodule

`default_nettype wire

>>> rtl/htfd_tracker.sv
// ----------------------------------------------------------------------------
// htfd_tracker
// Byte position, running CRC-8 and raw word capture; registers one frame
// word per completed reply.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_tracker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           byte_ready,
    input  wire logic [7:0]     byte_data,
    input  wire logic           byte_start,
    output logic                take,
    output logic                frame_valid,
    output htfd_pkg::frame_t    frame,
    input  wire logic           frame_ready
);
    import htfd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        fail_reg, fail_next;
    logic [15:0] t_word_reg, t_word_next;
    logic [7:0]  h_high_reg, h_high_next;
    logic [7:0]  h_low_reg, h_low_next;
    logic        f_valid_reg, f_valid_next;
    frame_t      f_reg, f_next;

    logic [2:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic        fail_eff;
    logic        last;
    logic        slot_free;
    logic [7:0]  crc_fed;

    // One byte through the CRC, bit by bit
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Frame-start mark restores position, CRC and failure flag
    always_comb
    begin
        pos_eff  = byte_start ? 3'(POS_T_HIGH) : pos_reg;
        crc_eff  = byte_start ? CRC_INIT : crc_reg;
        fail_eff = byte_start ? 1'b0 : fail_reg;
        last      = (pos_eff == 3'(POS_H_CRC));
        slot_free = !f_valid_reg || frame_ready;
        take      = byte_ready && (!last || slot_free);
        crc_fed   = crc8_feed(crc_eff, byte_data);
    end

    // Next state of the reply tracker
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        fail_next   = fail_reg;
        t_word_next = t_word_reg;
        h_high_next = h_high_reg;
        h_low_next  = h_low_reg;
        f_next      = f_reg;
        f_valid_next = slot_free ? 1'b0 : f_valid_reg;
        if (take)
        begin
            pos_next  = pos_eff;
            crc_next  = crc_eff;
            fail_next = fail_eff;
            unique case (pos_eff)
                3'(POS_T_LOW):
                begin
                    t_word_next = {t_word_reg[15:8], byte_data};
                    crc_next    = crc_fed;
                    pos_next    = 3'(POS_T_CRC);
                end
                3'(POS_T_CRC):
                begin
                    fail_next = fail_eff | (crc_eff != byte_data);
                    crc_next  = CRC_INIT;
                    pos_next  = 3'(POS_H_HIGH);
                end
                3'(POS_H_HIGH):
                begin
                    h_high_next = byte_data;
                    crc_next    = crc_fed;
                    pos_next    = 3'(POS_H_LOW);
                end
                3'(POS_H_LOW):
                begin
                    h_low_next = byte_data;
                    crc_next   = crc_fed;
                    pos_next   = 3'(POS_H_CRC);
                end
                3'(POS_H_CRC):
                begin
                    f_next.t_raw    = t_word_reg;
                    f_next.h_raw    = {h_high_reg, h_low_reg};
                    f_next.crc_fail = fail_eff | (crc_eff != byte_data);
                    f_valid_next    = 1'b1;
                    pos_next        = 3'(POS_T_HIGH);
                    crc_next        = CRC_INIT;
                    fail_next       = 1'b0;
                end
                // first byte; unused positions behave the same
                default:
                begin
                    t_word_next = {byte_data, 8'h00};
                    crc_next    = crc8_feed(CRC_INIT, byte_data);
                    pos_next    = 3'(POS_T_LOW);
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 3'(POS_T_HIGH);
            crc_reg     <= CRC_INIT;
            fail_reg    <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            fail_reg    <= fail_next;
            f_valid_reg <= f_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        t_word_reg <= t_word_next;
        h_high_reg <= h_high_next;
        h_low_reg  <= h_low_next;
        f_reg      <= f_next;
    end

    assign frame_valid = f_valid_reg;
    assign frame       = f_reg;

endmodule

`default_nettype wire

>>> rtl/htfd_scaler.sv
// ----------------------------------------------------------------------------
// htfd_scaler
// Scales raw words to hundredths: multiply stage, then divide by 65535
// with one correction step into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_scaler (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               frame_valid,
    input  htfd_pkg::frame_t        frame,
    output logic                    frame_ready,
    output logic                    res_valid,
    output logic signed [14:0]      res_temp,
    output logic [13:0]             res_hum,
    output logic                    res_status,
    input  wire logic               res_stall
);
    import htfd_pkg::*;

    logic               p_valid_reg, p_valid_next;
    logic [30:0]        t_prod_reg;
    logic [29:0]        h_prod_reg;
    logic               p_fail_reg;
    logic               o_valid_reg, o_valid_next;
    logic signed [14:0] temp_reg;
    logic [13:0]        hum_reg;
    logic               status_reg;

    logic               o_ready;
    logic [14:0]        t_q0;
    logic [16:0]        t_rem;
    logic [14:0]        t_quo;
    logic signed [15:0] temp_wide;
    logic [13:0]        h_q0;
    logic [16:0]        h_rem;
    logic [13:0]        h_quo;

    // Stage readiness
    always_comb
    begin
        o_ready      = !o_valid_reg || !res_stall;
        frame_ready  = !p_valid_reg || o_ready;
        p_valid_next = frame_ready ? frame_valid : p_valid_reg;
        o_valid_next = o_ready ? p_valid_reg : o_valid_reg;
    end

    // x / 65535 for x below 65535 * 2^15: quotient estimate plus one fix-up
    always_comb
    begin
        t_q0      = t_prod_reg[30:16];
        t_rem     = {1'b0, t_prod_reg[15:0]} + {2'b00, t_q0};
        t_quo     = t_q0 + {14'd0, (t_rem >= FULL_SCALE)};
        temp_wide = $signed({1'b0, t_quo}) - TEMP_OFFSET;
        h_q0      = h_prod_reg[29:16];
        h_rem     = {1'b0, h_prod_reg[15:0]} + {3'b000, h_q0};
        h_quo     = h_q0 + {13'd0, (h_rem >= FULL_SCALE)};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (frame_ready)
        begin
            t_prod_reg <= {15'd0, frame.t_raw} * {16'd0, TEMP_SCALE};
            h_prod_reg <= {14'd0, frame.h_raw} * {16'd0, HUM_SCALE};
            p_fail_reg <= frame.crc_fail;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (o_ready)
        begin
            temp_reg   <= temp_wide[14:0];
            hum_reg    <= h_quo;
            status_reg <= p_fail_reg;
        end
    end

    assign res_valid  = o_valid_reg;
    assign res_temp   = temp_reg;
    assign res_hum    = hum_reg;
    assign res_status = status_reg;

endmodule

`default_nettype wire

>>> verif/humidity_temp_frame_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_test
// Drives sensor reply bytes into the frame decoder under random idle and
// back-pressure. A scoreboard class tracks position, CRC-8 and the raw
// words, predicts each scaled reading and checks every result word in order.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_test;
    import htfd_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int BYTE_TARGET = 850;
    localparam int CYCLE_LIMIT = 300000;

    // One decoded reading as the block should report it
    typedef struct {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic               status;
    } reading_t;

    // Scoreboard: tracks the reply decoder state and the pending readings
    class reading_checker;
        pos_t        pos;
        logic [7:0]  crc;
        logic [15:0] t_word;
        logic [15:0] h_word;
        logic        failed;
        reading_t    expected_readings[$];
        int          errors;

        function new();
            pos    = POS_T_HIGH;
            crc    = CRC_INIT;
            t_word = '0;
            h_word = '0;
            failed = 1'b0;
            errors = 0;
        endfunction

        // One byte through the CRC-8 register, MSB first
        static function logic [7:0] crc8_feed(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            for (int k = 0; k < 8; k++)
                r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            return r;
        endfunction

        static function logic [7:0] word_crc(logic [15:0] w);
            return crc8_feed(crc8_feed(CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Accepted input byte: advance the decoder, queue a reading after byte six
        function void note_byte(logic [7:0] b, logic fs);
            reading_t    r;
            int unsigned tq;
            int unsigned hq;
            if (fs)
            begin
                pos    = POS_T_HIGH;
                crc    = CRC_INIT;
                failed = 1'b0;
            end
            case (pos)
                POS_T_LOW:
                begin
                    t_word[7:0] = b;
                    crc = crc8_feed(crc, b);
                    pos = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    if (crc != b)
                        failed = 1'b1;
                    crc = CRC_INIT;
                    pos = POS_H_HIGH;
                end
                POS_H_HIGH:
                begin
                    h_word[15:8] = b;
                    crc = crc8_feed(crc, b);
                    pos = POS_H_LOW;
                end
                POS_H_LOW:
                begin
                    h_word[7:0] = b;
                    crc = crc8_feed(crc, b);
                    pos = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    if (crc != b)
                        failed = 1'b1;
                    // truncating scale to hundredths, then the -45.00 C offset
                    tq = (32'(t_word) * 32'd17500) / 32'd65535;
                    hq = (32'(h_word) * 32'd10000) / 32'd65535;
                    r.temp   = 15'(int'(tq) - 4500);
                    r.hum    = 14'(hq);
                    r.status = failed;
                    expected_readings.push_back(r);
                    pos    = POS_T_HIGH;
                    crc    = CRC_INIT;
                    failed = 1'b0;
                end
                default:
                begin
                    // first byte; unused positions land here too
                    t_word = {b, 8'h00};
                    crc    = crc8_feed(CRC_INIT, b);
                    pos    = POS_T_LOW;
                end
            endcase
        endfunction

        // Accepted result word: compare with the oldest pending reading
        function void check_reading(logic signed [14:0] t, logic [13:0] h, logic s);
            reading_t e;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected result word temp=%0d hum=%0d status=%0b",
                         $time, t, h, s);
                errors++;
                return;
            end
            e = expected_readings.pop_front();
            if (t !== e.temp)
            begin
                $display("%0t: temperature_centi expected %0d actual %0d",
                         $time, e.temp, t);
                errors++;
            end
            if (h !== e.hum)
            begin
                $display("%0t: humidity_centi expected %0d actual %0d", $time, e.hum, h);
                errors++;
            end
            if (s !== e.status)
            begin
                $display("%0t: frame_status expected %0b actual %0b", $time, e.status, s);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_stall;
    logic [7:0]          rx_byte;
    logic                frame_start;
    logic                result_valid;
    logic                result_stall;
    logic signed [14:0]  temperature_centi;
    logic [13:0]         humidity_centi;
    logic                frame_status;

    reading_checker sb;
    int             bytes_sent;
    int             send_idle_pct;
    int             stall_pct;
    int             cycle_count;
    bit             need_mark;
    bit             drained_once;

    humidity_temp_frame_decoder u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .rx_byte           (rx_byte),
        .frame_start       (frame_start),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .frame_status      (frame_status)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side back-pressure in bursts
    initial
    begin
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_reading(temperature_centi, humidity_centi, frame_status);
    end

    // One input word, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic fs);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        byte_valid  <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        do
            @(posedge clk);
        while (byte_stall);
        sb.note_byte(b, fs);
        bytes_sent++;
    endtask

    // Full six-byte reply; bad CRCs get a nonzero error pattern
    task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                              input bit t_bad, input bit h_bad, input logic fs);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = reading_checker::word_crc(t) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        hc = reading_checker::word_crc(h) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        send_byte(t[15:8], fs);
        send_byte(t[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    // Sender holds off until every pending reading is out
    task automatic drain_results();
        if (sb.pending() != 0)
        begin
            byte_valid <= 1'b0;
            while (sb.pending() != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            3:       return 16'hFFFE;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int          kind;
        int          n;
        logic [15:0] t;
        logic [15:0] h;
        sb            = new();
        rst_n         = 1'b0;
        byte_valid    = 1'b0;
        rx_byte       = 8'h00;
        frame_start   = 1'b0;
        bytes_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        need_mark     = 1'b0;
        drained_once  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, CRC failures, abort by a new frame start,
        // back to back replies without the mark
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);
        send_frame(16'h0001, 16'hFFFE, 1'b1, 1'b1, 1'b0);
        drain_results();

        // Random replies with occasional noise and truncated replies
        send_idle_pct = 20;
        stall_pct     = 20;
        while (bytes_sent < BYTE_TARGET)
        begin
            if (bytes_sent > BYTE_TARGET - 120)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 60);
                stall_pct     = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 60);
            end
            if (!drained_once && bytes_sent > BYTE_TARGET / 2)
            begin
                drain_results();
                drained_once = 1'b1;
            end
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                // noise bytes, mark set at random
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                need_mark = 1'b1;
            end
            else if (kind == 1)
            begin
                // truncated reply, the next one must restart with the mark
                t = pick_word();
                n = $urandom_range(1, 5);
                send_byte(t[15:8], 1'b1);
                if (n > 1) send_byte(t[7:0], 1'b0);
                if (n > 2) send_byte(reading_checker::word_crc(t), 1'b0);
                if (n > 3) send_byte(8'($urandom_range(0, 255)), 1'b0);
                if (n > 4) send_byte(8'($urandom_range(0, 255)), 1'b0);
                need_mark = 1'b1;
            end
            else
            begin
                t = pick_word();
                h = pick_word();
                send_frame(t, h, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                           need_mark ? 1'b1 : 1'($urandom_range(0, 1)));
                need_mark = 1'b0;
            end
        end

        // Wind down
        byte_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
